@@ hdl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CAL_ZERO  = 3'd1,
    ST_CAL_ONES  = 3'd2,
    ST_ZERO_READ = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_RANGE     = 3'd5
  } status_t;

  localparam logic [2:0] REG_SENS     = 3'd0;
  localparam logic [2:0] REG_OFF      = 3'd1;
  localparam logic [2:0] REG_SENS_TC  = 3'd2;
  localparam logic [2:0] REG_OFF_TC   = 3'd3;
  localparam logic [2:0] REG_REF_TEMP = 3'd4;
  localparam logic [2:0] REG_TEMP_TC  = 3'd5;

  localparam int NSTAGE = 9;

  typedef struct packed {
    logic [15:0] sens;
    logic [15:0] off;
    logic [15:0] sens_tc;
    logic [15:0] off_tc;
    logic [15:0] ref_temp;
    logic [15:0] temp_tc;
  } cal_t;

  // first-order results handed from front to second-order stages
  typedef struct packed {
    logic signed [19:0] temp1;
    logic signed [36:0] off1;
    logic signed [35:0] sens1;
    logic        [18:0] t2;
    logic        [23:0] d1;
    status_t            st;
  } first_t;

  // corrected terms handed to the pressure stages
  typedef struct packed {
    logic signed [19:0] temp;
    logic signed [42:0] off;
    logic signed [42:0] sens;
    logic        [23:0] d1;
    status_t            st;
  } corr_t;

endpackage

`default_nettype wire

@@ hdl/barometric_pressure_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Second-order temperature compensation of raw barometer conversions.
// ----------------------------------------------------------------------------
// Takes one raw pressure/temperature pair per transfer and returns one result;
// a new pair is taken every cycle unless stalled. The nine-stage pipeline is
// set by the chain of squarings and the 24 x 43 bit pressure product split in
// two partial products. Stages stall independently, so bubbles close up when
// the output is held. The user must write calibration words through the cfg
// channel only while no item is in flight; the block does not enforce this.
`default_nettype none

module barometric_pressure_compensation_unit
  import bpc_pkg::*;
#(
  parameter int ADC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // raw_pressure, raw_temperature
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // temperature_milli, pressure, pad
  output logic [2:0]       out_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cal_t               cal_r;
  logic [NSTAGE-1:0]  v_r;
  logic [NSTAGE-1:0]  en;
  logic [23:0]        raw_p, raw_t;
  status_t            st_in;
  first_t             first;
  corr_t              corr;
  status_t            status;
  logic [22:0]        tm;
  logic [31:0]        pr;

  assign raw_p = in_tdata[23:0];
  assign raw_t = in_tdata[47:24];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENS:     cal_r.sens     <= cfg_data;
        REG_OFF:      cal_r.off      <= cfg_data;
        REG_SENS_TC:  cal_r.sens_tc  <= cfg_data;
        REG_OFF_TC:   cal_r.off_tc   <= cfg_data;
        REG_REF_TEMP: cal_r.ref_temp <= cfg_data;
        REG_TEMP_TC:  cal_r.temp_tc  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cal_r == '0) begin
      st_in = ST_CAL_ZERO;
    end else if (cal_r == '1) begin
      st_in = ST_CAL_ONES;
    end else if (raw_p == '0 || raw_t == '0) begin
      st_in = ST_ZERO_READ;
    end else if ((25'(raw_p) >> ADC_BITS) != '0 || (25'(raw_t) >> ADC_BITS) != '0) begin
      st_in = ST_TOO_LARGE;
    end else begin
      st_in = ST_OK;
    end
  end

  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  bpc_front u_front (
    .clk   (clk),
    .en    (en[2:0]),
    .cal   (cal_r),
    .raw_p (raw_p),
    .raw_t (raw_t),
    .st_in (st_in),
    .first (first)
  );

  bpc_second u_second (
    .clk   (clk),
    .en    (en[5:3]),
    .first (first),
    .corr  (corr)
  );

  bpc_press u_press (
    .clk               (clk),
    .en                (en[8:6]),
    .corr              (corr),
    .status            (status),
    .temperature_milli (tm),
    .pressure          (pr)
  );

  assign out_tvalid = v_r[NSTAGE-1];
  assign out_tdata  = {1'b0, pr, tm};
  assign out_tuser  = status;

endmodule

`default_nettype wire

@@ hdl/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// Temperature difference, coefficient products and first-order terms.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front
  import bpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire cal_t        cal,
  input  wire logic [23:0] raw_p,
  input  wire logic [23:0] raw_t,
  input  wire status_t     st_in,
  output first_t           first
);

  logic signed [24:0] dt_r;
  logic        [23:0] d1_r, d1b_r;
  status_t            st_r, stb_r;
  logic signed [41:0] pt_r, po_r, ps_r;
  logic signed [49:0] sq_r;
  first_t             first_r;

  logic signed [24:0] dt_nxt;
  logic signed [41:0] pt_q, po_q, ps_q;
  first_t             first_nxt;

  assign dt_nxt = $signed({1'b0, raw_t}) - $signed({1'b0, cal.ref_temp, 8'h00});

  always_comb begin
    pt_q = (pt_r + (pt_r[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    po_q = (po_r + (po_r[41] ? 42'sd127 : 42'sd0)) >>> 7;
    ps_q = (ps_r + (ps_r[41] ? 42'sd255 : 42'sd0)) >>> 8;
    first_nxt.temp1 = pt_q[19:0] + 20'sd2000;
    first_nxt.off1  = $signed({5'b0, cal.off, 16'h0000}) + po_q[36:0];
    first_nxt.sens1 = $signed({5'b0, cal.sens, 15'h0000}) + ps_q[35:0];
    first_nxt.t2    = sq_r[49:31];
    first_nxt.d1    = d1b_r;
    first_nxt.st    = stb_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r <= dt_nxt;
      d1_r <= raw_p;
      st_r <= st_in;
    end
    if (en[1]) begin
      pt_r  <= dt_r * $signed({1'b0, cal.temp_tc});
      po_r  <= dt_r * $signed({1'b0, cal.off_tc});
      ps_r  <= dt_r * $signed({1'b0, cal.sens_tc});
      sq_r  <= dt_r * dt_r;
      d1b_r <= d1_r;
      stb_r <= st_r;
    end
    if (en[2]) begin
      first_r <= first_nxt;
    end
  end

  assign first = first_r;

endmodule

`default_nettype wire

@@ hdl/bpc_second.sv @@
// ----------------------------------------------------------------------------
// bpc_second
// Second-order correction below 20 C and below -15 C.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_second
  import bpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic [2:0] en,
  input  wire first_t first,
  output corr_t      corr
);

  first_t             f_r, g_r;
  logic signed [41:0] sqa_r, sqb_r;
  logic               cold_r, vcold_r;
  logic        [41:0] off2_r, sens2_r;
  logic signed [19:0] temp_r;
  corr_t              corr_r;

  logic signed [20:0] a, b;
  logic        [41:0] off2_nxt, sens2_nxt, sa5, sb7, sb11;

  assign a = {first.temp1[19], first.temp1} - 21'sd2000;
  assign b = {first.temp1[19], first.temp1} + 21'sd1500;

  always_comb begin
    sa5  = 42'(unsigned'(sqa_r)) * 42'd5;
    sb7  = 42'(unsigned'(sqb_r)) * 42'd7;
    sb11 = 42'(unsigned'(sqb_r)) * 42'd11;
    off2_nxt  = 42'd0;
    sens2_nxt = 42'd0;
    if (cold_r) begin
      off2_nxt  = sa5 >> 1;
      sens2_nxt = sa5 >> 2;
      if (vcold_r) begin
        off2_nxt  = off2_nxt + sb7;
        sens2_nxt = sens2_nxt + (sb11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sqa_r   <= a * a;
      sqb_r   <= b * b;
      cold_r  <= first.temp1 < 20'sd2000;
      vcold_r <= first.temp1 < -20'sd1500;
      f_r     <= first;
    end
    if (en[1]) begin
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
      temp_r  <= f_r.temp1 - (cold_r ? $signed({1'b0, f_r.t2}) : 20'sd0);
      g_r     <= f_r;
    end
    if (en[2]) begin
      corr_r.temp <= temp_r;
      corr_r.off  <= 43'(g_r.off1) - $signed({1'b0, off2_r});
      corr_r.sens <= 43'(g_r.sens1) - $signed({1'b0, sens2_r});
      corr_r.d1   <= g_r.d1;
      corr_r.st   <= g_r.st;
    end
  end

  assign corr = corr_r;

endmodule

`default_nettype wire

@@ hdl/bpc_press.sv @@
// ----------------------------------------------------------------------------
// bpc_press
// Split pressure product, final scaling, range check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_press
  import bpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire corr_t       corr,
  output status_t          status,
  output logic [22:0]      temperature_milli,
  output logic [31:0]      pressure
);

  logic        [43:0] plo_r;
  logic signed [47:0] phi_r;
  corr_t              c1_r, c2_r;
  logic signed [47:0] x_r;
  status_t            st_r;
  logic        [22:0] tm_r;
  logic        [31:0] pr_r;

  logic signed [67:0] prod, q;
  logic signed [47:0] x_nxt, p;
  logic signed [31:0] temp_h;
  logic               bad;
  status_t            st_nxt;

  always_comb begin
    prod  = (68'(phi_r) <<< 20) + $signed({24'b0, plo_r});
    q     = (prod + (prod[67] ? 68'sd2097151 : 68'sd0)) >>> 21;
    x_nxt = q[47:0] - 48'(c1_r.off);
    p     = (x_r + (x_r[47] ? 48'sd32767 : 48'sd0)) >>> 15;
    temp_h = 32'(c2_r.temp);
    bad = (temp_h < -32'sd214748364) || (temp_h > 32'sd214748364) ||
          (p > 48'sd2147483647) || (p < -48'sd2147483648);
    st_nxt = c2_r.st;
    if (c2_r.st == ST_OK && bad) begin
      st_nxt = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo_r <= 44'(corr.d1) * 44'(corr.sens[19:0]);
      phi_r <= $signed({1'b0, corr.d1}) * $signed(corr.sens[42:20]);
      c1_r  <= corr;
    end
    if (en[1]) begin
      x_r  <= x_nxt;
      c2_r <= c1_r;
    end
    if (en[2]) begin
      st_r <= st_nxt;
      if (st_nxt == ST_OK) begin
        tm_r <= 23'(c2_r.temp) * 23'sd10;
        pr_r <= p[31:0];
      end else begin
        tm_r <= '0;
        pr_r <= '0;
      end
    end
  end

  assign status            = st_r;
  assign temperature_milli = tm_r;
  assign pressure          = pr_r;

endmodule

`default_nettype wire

@@ hdl/bpc_checker.sv @@
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_checker
  import bpc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("error result carries nonzero data");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_RANGE)
    else $error("status code out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
